FILE: src/tdsp_pkg.sv
// ----------------------------------------------------------------------------
// Time and date string parser package
// Shared types, character codes and limits for the parser modules.
// ----------------------------------------------------------------------------
package tdsp_pkg;

  localparam int VAL_W  = 14;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int QDEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DIG0   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG9   = 8'h39;

  localparam logic [STAT_W-1:0] ST_PARSED    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLASH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_PERIOD = 2'd2;

  localparam logic [VAL_W-1:0] HOUR_LIMIT     = 14'd24;
  localparam logic [VAL_W-1:0] MIN_SEC_LIMIT  = 14'd60;
  localparam logic [VAL_W-1:0] MONTH_LIMIT    = 14'd13;
  localparam logic [VAL_W-1:0] DAY_LIMIT      = 14'd32;
  localparam logic [VAL_W-1:0] YEAR_MIN_RESET = 14'd2000;

  // character classes as seen by the back end
  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_COLON  = 3'd1,
    CLS_SLASH  = 3'd2,
    CLS_COMMA  = 3'd3,
    CLS_PERIOD = 3'd4,
    CLS_DIGIT  = 3'd5,
    CLS_OTHER  = 3'd6
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } token_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
  } q_stat_t;

  // queue output seen by the back end
  typedef struct packed {
    logic   valid;
    token_t tok;
  } q_head_t;

  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_TIME = 3'b010,
    PH_DATE = 3'b100
  } phase_t;

endpackage

FILE: src/tdsp_ifs.sv
// ----------------------------------------------------------------------------
// Parser channel interfaces
// Character request channel and parse result channel, valid/ready.
// ----------------------------------------------------------------------------
interface tdsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdsp_pkg::CHAR_W-1:0]  char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface tdsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [tdsp_pkg::STAT_W-1:0]  status;
  logic [tdsp_pkg::VAL_W-1:0]   hours;
  logic [tdsp_pkg::VAL_W-1:0]   minutes;
  logic [tdsp_pkg::VAL_W-1:0]   seconds;
  logic [tdsp_pkg::VAL_W-1:0]   month;
  logic [tdsp_pkg::VAL_W-1:0]   day;
  logic [tdsp_pkg::VAL_W-1:0]   year;
  logic                         time_ok;
  logic                         date_ok;

  modport source (output valid, output status, output hours, output minutes,
                  output seconds, output month, output day, output year,
                  output time_ok, output date_ok, input ready);
  modport sink   (input valid, input status, input hours, input minutes,
                  input seconds, input month, input day, input year,
                  input time_ok, input date_ok, output ready);
endinterface

FILE: src/tdsp_front.sv
// ----------------------------------------------------------------------------
// Parser front end
// Accept character requests and classify them into tokens for the queue.
// ----------------------------------------------------------------------------
module tdsp_front (
  tdsp_in_if.sink            in_ch,
  input  tdsp_pkg::q_stat_t  q_stat,
  output logic               push,
  output tdsp_pkg::token_t   push_tok
);

  logic [tdsp_pkg::CHAR_W-1:0] c;
  logic [tdsp_pkg::CHAR_W-1:0] c_off;

  assign c     = in_ch.char_byte;
  assign c_off = c - tdsp_pkg::CH_DIG0;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_tok.digit = c_off[3:0];
    if (c == tdsp_pkg::CH_ZERO) begin
      push_tok.cls = tdsp_pkg::CLS_ZERO;
    end else if (c == tdsp_pkg::CH_COLON) begin
      push_tok.cls = tdsp_pkg::CLS_COLON;
    end else if (c == tdsp_pkg::CH_SLASH) begin
      push_tok.cls = tdsp_pkg::CLS_SLASH;
    end else if (c == tdsp_pkg::CH_COMMA) begin
      push_tok.cls = tdsp_pkg::CLS_COMMA;
    end else if (c == tdsp_pkg::CH_PERIOD) begin
      push_tok.cls = tdsp_pkg::CLS_PERIOD;
    end else if (c >= tdsp_pkg::CH_DIG0 && c <= tdsp_pkg::CH_DIG9) begin
      push_tok.cls = tdsp_pkg::CLS_DIGIT;
    end else begin
      push_tok.cls = tdsp_pkg::CLS_OTHER;
    end
  end

endmodule

FILE: src/tdsp_queue.sv
// ----------------------------------------------------------------------------
// Token queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tdsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tdsp_pkg::token_t   push_tok,
  input  logic               pop,
  output tdsp_pkg::q_stat_t  q_stat,
  output tdsp_pkg::q_head_t  q_head
);

  localparam int PTR_W = $clog2(tdsp_pkg::QDEPTH);
  localparam int CNT_W = $clog2(tdsp_pkg::QDEPTH + 1);

  tdsp_pkg::token_t  slot_r [tdsp_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(tdsp_pkg::QDEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.tok   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tdsp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tdsp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

FILE: src/tdsp_back.sv
// ----------------------------------------------------------------------------
// Parser back end
// Run the message state machine on tokens and register the parse result.
// ----------------------------------------------------------------------------
module tdsp_back #(
  parameter int FIELD_CHARS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tdsp_pkg::VAL_W-1:0]   cfg_wdata,
  input  tdsp_pkg::q_head_t            q_head,
  output logic                         pop,
  tdsp_out_if.source                   out_ch
);

  localparam int CNT_W = $clog2(FIELD_CHARS + 1);
  localparam int VW    = tdsp_pkg::VAL_W;

  tdsp_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]        fidx_r, fidx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              stop_r, stop_nxt;
  logic [VW-1:0]     acc_r, acc_nxt;
  logic [VW-1:0]     tv_r [3];
  logic [VW-1:0]     tv_nxt [3];
  logic [VW-1:0]     dv_r [3];
  logic [VW-1:0]     dv_nxt [3];
  logic [VW-1:0]     dv_fin [3];
  logic [VW-1:0]     year_min_r;
  logic [VW-1:0]     acc_x10;

  logic                         ovalid_r, ovalid_nxt;
  logic                         emit;
  logic [tdsp_pkg::STAT_W-1:0]  ostat_nxt, ostat_r;
  logic [VW-1:0]                oval_nxt [6];
  logic [VW-1:0]                oval_r [6];
  logic                         tok_nxt, tok_r, dok_nxt, dok_r;

  tdsp_pkg::cls_t    cls;
  logic              is_digit;
  logic              take;
  logic              close_t, close_d;
  logic              clear_msg;

  assign cls     = q_head.tok.cls;
  assign pop     = q_head.valid && (!ovalid_r || out_ch.ready);
  assign acc_x10 = {acc_r[VW-4:0], 3'b000} + {acc_r[VW-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_fin[i] = (fidx_r == 2'(i)) ? acc_r : dv_r[i];
    end
  end

  // decode the token against the current phase
  always_comb begin
    phase_nxt = phase_r;
    fidx_nxt  = fidx_r;
    take      = 1'b0;
    close_t   = 1'b0;
    close_d   = 1'b0;
    emit      = 1'b0;
    clear_msg = 1'b0;
    ostat_nxt = tdsp_pkg::ST_PARSED;
    is_digit  = (cls == tdsp_pkg::CLS_DIGIT);
    if (pop) begin
      case (phase_r)
        tdsp_pkg::PH_LEAD: begin
          if (cls == tdsp_pkg::CLS_ZERO) begin
            emit      = 1'b1;
            clear_msg = 1'b1;
            ostat_nxt = tdsp_pkg::ST_NO_SLASH;
          end else begin
            phase_nxt = tdsp_pkg::PH_TIME;
          end
        end
        tdsp_pkg::PH_TIME: begin
          case (cls)
            tdsp_pkg::CLS_ZERO: begin
              emit      = 1'b1;
              clear_msg = 1'b1;
              ostat_nxt = tdsp_pkg::ST_NO_SLASH;
            end
            tdsp_pkg::CLS_SLASH: begin
              close_t   = 1'b1;
              fidx_nxt  = 2'd0;
              phase_nxt = tdsp_pkg::PH_DATE;
            end
            tdsp_pkg::CLS_COLON: begin
              if (fidx_r < 2'd2) begin
                close_t  = 1'b1;
                fidx_nxt = fidx_r + 2'd1;
              end
            end
            default: begin
              take = 1'b1;
            end
          endcase
        end
        tdsp_pkg::PH_DATE: begin
          case (cls)
            tdsp_pkg::CLS_ZERO: begin
              emit      = 1'b1;
              clear_msg = 1'b1;
              ostat_nxt = tdsp_pkg::ST_NO_PERIOD;
            end
            tdsp_pkg::CLS_PERIOD: begin
              emit      = 1'b1;
              clear_msg = 1'b1;
            end
            tdsp_pkg::CLS_COMMA: begin
              if (fidx_r < 2'd2) begin
                close_d  = 1'b1;
                fidx_nxt = fidx_r + 2'd1;
              end
            end
            default: begin
              take = 1'b1;
            end
          endcase
        end
        default: begin
          phase_nxt = tdsp_pkg::PH_LEAD;
        end
      endcase
    end
    if (clear_msg) begin
      phase_nxt = tdsp_pkg::PH_LEAD;
      fidx_nxt  = 2'd0;
    end
  end

  // field accumulator and value stores
  always_comb begin
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    acc_nxt  = acc_r;
    for (int i = 0; i < 3; i++) begin
      tv_nxt[i] = tv_r[i];
      dv_nxt[i] = dv_r[i];
    end
    if (take && cnt_r < CNT_W'(FIELD_CHARS)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (!stop_r) begin
        if (is_digit) begin
          acc_nxt = acc_x10 + VW'(q_head.tok.digit);
        end else begin
          stop_nxt = 1'b1;
        end
      end
    end
    if (close_t || close_d || clear_msg) begin
      cnt_nxt  = '0;
      stop_nxt = 1'b0;
      acc_nxt  = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (close_t && fidx_r == 2'(i)) begin
        tv_nxt[i] = acc_r;
      end
      if (close_d && fidx_r == 2'(i)) begin
        dv_nxt[i] = acc_r;
      end
      if (clear_msg) begin
        tv_nxt[i] = '0;
        dv_nxt[i] = '0;
      end
    end
  end

  // result payload: values only on a clean parse, zero on error
  always_comb begin
    tok_nxt = 1'b0;
    dok_nxt = 1'b0;
    for (int i = 0; i < 6; i++) begin
      oval_nxt[i] = '0;
    end
    if (ostat_nxt == tdsp_pkg::ST_PARSED) begin
      for (int i = 0; i < 3; i++) begin
        oval_nxt[i]     = tv_r[i];
        oval_nxt[i + 3] = dv_fin[i];
      end
      tok_nxt = (tv_r[0] < tdsp_pkg::HOUR_LIMIT) && (tv_r[1] < tdsp_pkg::MIN_SEC_LIMIT) &&
                (tv_r[2] < tdsp_pkg::MIN_SEC_LIMIT);
      dok_nxt = (dv_fin[0] < tdsp_pkg::MONTH_LIMIT) && (dv_fin[1] < tdsp_pkg::DAY_LIMIT) &&
                (dv_fin[2] >= year_min_r);
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (emit) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tdsp_pkg::PH_LEAD;
      fidx_r     <= 2'd0;
      cnt_r      <= '0;
      stop_r     <= 1'b0;
      acc_r      <= '0;
      ovalid_r   <= 1'b0;
      year_min_r <= tdsp_pkg::YEAR_MIN_RESET;
      for (int i = 0; i < 3; i++) begin
        tv_r[i] <= '0;
        dv_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      fidx_r   <= fidx_nxt;
      cnt_r    <= cnt_nxt;
      stop_r   <= stop_nxt;
      acc_r    <= acc_nxt;
      ovalid_r <= ovalid_nxt;
      for (int i = 0; i < 3; i++) begin
        tv_r[i] <= tv_nxt[i];
        dv_r[i] <= dv_nxt[i];
      end
      if (cfg_we) begin
        year_min_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ostat_r <= ostat_nxt;
      tok_r   <= tok_nxt;
      dok_r   <= dok_nxt;
      for (int i = 0; i < 6; i++) begin
        oval_r[i] <= oval_nxt[i];
      end
    end
  end

  assign out_ch.valid   = ovalid_r;
  assign out_ch.status  = ostat_r;
  assign out_ch.hours   = oval_r[0];
  assign out_ch.minutes = oval_r[1];
  assign out_ch.seconds = oval_r[2];
  assign out_ch.month   = oval_r[3];
  assign out_ch.day     = oval_r[4];
  assign out_ch.year    = oval_r[5];
  assign out_ch.time_ok = tok_r;
  assign out_ch.date_ok = dok_r;

endmodule

FILE: src/time_date_string_parser_top.sv
// Result path: the closing character is held in the token queue; the back end then
//   registers the result, and the result request leaves from that result register.
// Throughput: one character per cycle;
//   the back end stalls only while a finished result waits on out_ch.
// Reset: synchronous, active low; clears the queue, the message state and sets
//   year_minimum to 2000. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Time and date string parser, top level
// Parse "Lh:m:s/month,day,year." one character per request into six values
// with range flags, or an error status on an early end of string.
// ----------------------------------------------------------------------------
module time_date_string_parser_top #(
  parameter int FIELD_CHARS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tdsp_pkg::VAL_W-1:0]  cfg_wdata,
  tdsp_in_if.sink                     in_ch,
  tdsp_out_if.source                  out_ch
);

  // front to queue: classified token and queue fill status
  logic               push;
  tdsp_pkg::token_t   push_tok;
  tdsp_pkg::q_stat_t  q_stat;

  // queue to back: head token and pop strobe
  tdsp_pkg::q_head_t  q_head;
  logic               pop;

  // Classify each character as it is accepted; hold in_ch off only when
  // the queue is full.
  tdsp_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_tok (push_tok)
  );

  // Short queue so a stalled result does not stall the character stream
  // at once.
  tdsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .q_stat   (q_stat),
    .q_head   (q_head)
  );

  // Advance the message state machine, build field values, drive results.
  tdsp_back #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
